[hw/rtl/vsc_pkg.sv]
package vsc_pkg;

   // Default and upper bound of the number of dotted parts
   localparam int PARTS_MAX_DEF = 4;
   localparam int PARTS_CAP     = 8;

   // Count field wide enough for any part count in the parameter range
   localparam int CNT_W = $clog2(PARTS_CAP + 1);

   // Part accumulator: 100000000 * 10 + 9 still fits in 30 bits
   localparam int ACC_W = 30;
   localparam logic [ACC_W-1:0] PART_LIMIT = 30'd100000000;

   // Queue depth between parser and comparator
   localparam int Q_DEPTH = 2;

   // Character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_V_UP  = 8'h56;
   localparam logic [7:0] CH_V_LO  = 8'h76;

   // Parser phases
   typedef enum logic [2:0] {
      PH_LEAD,
      PH_AFTER_V,
      PH_DIGITS,
      PH_AFTER_DOT,
      PH_TAIL,
      PH_BAD
   } phase_type;

   // Ordering codes, first versus second
   typedef logic signed [1:0] order_type;
   localparam order_type ORD_EQ = 2'sb00;
   localparam order_type ORD_GT = 2'sb01;
   localparam order_type ORD_LT = 2'sb11;

   // Parser event handed to the comparator
   typedef struct packed {
      logic             cmd;
      logic             has_part;
      logic [CNT_W-1:0] part_idx;
      logic [ACC_W-1:0] part_val;
      logic             has_term;
      logic             ok;
      logic [CNT_W-1:0] count;
   } event_type;

endpackage

[hw/rtl/vsc_front.sv]
module vsc_front #(
   parameter int PARTS_MAX = vsc_pkg::PARTS_MAX_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command,
   input  logic [7:0]          req_char_code,
   input  logic                q_full,
   output logic                q_push,
   output vsc_pkg::event_type  q_evt
);
   import vsc_pkg::*;

   localparam int CntW = $clog2(PARTS_MAX + 1);

   phase_type        phase_ff, phase_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [CntW-1:0]  idx_ff, idx_in;
   logic [CntW-1:0]  idx_inc;
   logic             room;
   logic             is_digit;
   logic [3:0]       digit;
   logic             accept;
   event_type        evt;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign is_digit  = (req_char_code >= CH_ZERO) && (req_char_code <= CH_NINE);
   assign digit     = req_char_code[3:0];
   assign idx_inc   = CntW'(idx_ff + 1'b1);
   assign room      = idx_ff < CntW'(PARTS_MAX);

   // Classify the byte and build the event it raises
   always_comb begin
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      idx_in       = idx_ff;
      evt.cmd      = req_command;
      evt.has_part = 1'b0;
      evt.part_idx = CNT_W'(idx_ff);
      evt.part_val = acc_ff;
      evt.has_term = 1'b0;
      evt.ok       = 1'b0;
      evt.count    = '0;
      case (phase_ff)
         PH_LEAD: begin
            if (req_char_code == CH_NUL) begin
               evt.has_term = 1'b1;
            end else if (req_char_code == CH_SPACE || req_char_code == CH_TAB) begin
               phase_in = PH_LEAD;
            end else if (req_char_code == CH_V_LO || req_char_code == CH_V_UP) begin
               phase_in = PH_AFTER_V;
            end else if (is_digit) begin
               acc_in   = ACC_W'(digit);
               phase_in = PH_DIGITS;
            end else begin
               phase_in = PH_BAD;
            end
         end
         PH_AFTER_V, PH_AFTER_DOT: begin
            if (req_char_code == CH_NUL) begin
               evt.has_term = 1'b1;
            end else if (is_digit) begin
               acc_in   = ACC_W'(digit);
               phase_in = PH_DIGITS;
            end else begin
               phase_in = PH_BAD;
            end
         end
         PH_DIGITS: begin
            if (is_digit) begin
               if (acc_ff > PART_LIMIT) begin
                  phase_in = PH_BAD;
               end else begin
                  acc_in = (acc_ff << 3) + (acc_ff << 1) + ACC_W'(digit);
               end
            end else if (req_char_code == CH_DOT) begin
               if (room) begin
                  evt.has_part = 1'b1;
                  idx_in       = idx_inc;
                  acc_in       = '0;
                  phase_in     = (idx_inc >= CntW'(PARTS_MAX)) ? PH_BAD : PH_AFTER_DOT;
               end else begin
                  phase_in = PH_BAD;
               end
            end else if (req_char_code == CH_NUL) begin
               evt.has_term = 1'b1;
               if (room) begin
                  evt.has_part = 1'b1;
                  evt.ok       = 1'b1;
                  evt.count    = CNT_W'(idx_inc);
               end
            end else if (req_char_code == CH_MINUS || req_char_code == CH_PLUS ||
                         req_char_code == CH_SPACE) begin
               if (room) begin
                  evt.has_part = 1'b1;
                  idx_in       = idx_inc;
                  acc_in       = '0;
                  phase_in     = PH_TAIL;
               end else begin
                  phase_in = PH_BAD;
               end
            end else begin
               phase_in = PH_BAD;
            end
         end
         PH_TAIL: begin
            if (req_char_code == CH_NUL) begin
               evt.has_term = 1'b1;
               evt.ok       = 1'b1;
               evt.count    = CNT_W'(idx_ff);
            end
         end
         default: begin
            phase_in = PH_BAD;
            if (req_char_code == CH_NUL) begin
               evt.has_term = 1'b1;
            end
         end
      endcase
      // Restart the parser after every terminator
      if (evt.has_term) begin
         phase_in = PH_LEAD;
         acc_in   = '0;
         idx_in   = '0;
      end
   end

   assign q_push = accept && (evt.has_part || evt.has_term);
   assign q_evt  = evt;

   // Advance the parser on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         acc_ff   <= '0;
         idx_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

[hw/rtl/vsc_queue.sv]
module vsc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  vsc_pkg::event_type  push_evt,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output vsc_pkg::event_type  head_evt
);
   import vsc_pkg::*;

   localparam int PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CntW = $clog2(Q_DEPTH + 1);

   event_type       slot_ff [Q_DEPTH];
   logic [PtrW-1:0] wr_ff, wr_in;
   logic [PtrW-1:0] rd_ff, rd_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign full     = cnt_ff == CntW'(Q_DEPTH);
   assign empty    = cnt_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_evt = slot_ff[rd_ff];

   // Wrap pointers and track occupancy
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PtrW'(Q_DEPTH - 1)) ? '0 : PtrW'(wr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PtrW'(Q_DEPTH - 1)) ? '0 : PtrW'(rd_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         cnt_in = CntW'(cnt_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         cnt_in = CntW'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the incoming beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_evt;
      end
   end

endmodule

[hw/rtl/vsc_back.sv]
module vsc_back #(
   parameter int PARTS_MAX = vsc_pkg::PARTS_MAX_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  vsc_pkg::event_type  q_evt,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_which_string,
   output logic                rsp_parse_ok,
   output logic [2:0]          rsp_part_count,
   output logic signed [1:0]   rsp_order,
   output logic                rsp_downgrade
);
   import vsc_pkg::*;

   localparam int IdxW = (PARTS_MAX > 1) ? $clog2(PARTS_MAX) : 1;

   logic [ACC_W-1:0] parts_ff [PARTS_MAX];
   logic [ACC_W-1:0] parts_in [PARTS_MAX];
   logic             first_valid_ff, first_valid_in;
   order_type        run_ord_ff, run_ord_in;
   order_type        ord_mid, res_ord;
   logic [IdxW-1:0]  idx;
   logic [ACC_W-1:0] cur;
   logic             tail_nz;
   logic             load;

   logic             valid_ff, valid_in;
   logic             which_ff;
   logic             ok_ff;
   logic [2:0]       count_ff;
   order_type        ord_ff;
   logic             dg_ff;

   assign idx   = q_evt.part_idx[IdxW-1:0];
   assign cur   = parts_ff[idx];
   assign q_pop = !q_empty && (!q_evt.has_term || !valid_ff || rsp_ready);
   assign load  = q_pop && q_evt.has_term;

   // Store or compare the finished part, then settle a terminator
   always_comb begin
      parts_in       = parts_ff;
      first_valid_in = first_valid_ff;
      ord_mid        = run_ord_ff;
      res_ord        = ORD_EQ;
      tail_nz        = 1'b0;
      if (q_evt.has_part) begin
         if (!q_evt.cmd) begin
            parts_in[idx] = q_evt.part_val;
         end else if (run_ord_ff == ORD_EQ) begin
            if (cur > q_evt.part_val) begin
               ord_mid = ORD_GT;
            end else if (cur < q_evt.part_val) begin
               ord_mid = ORD_LT;
            end
         end
      end
      // Missing parts of the second string count as zero
      for (int i = 0; i < PARTS_MAX; i++) begin
         if (CNT_W'(i) >= q_evt.count && parts_in[i] != '0) begin
            tail_nz = 1'b1;
         end
      end
      run_ord_in = ord_mid;
      if (q_evt.has_term) begin
         run_ord_in = ORD_EQ;
         if (!q_evt.cmd) begin
            first_valid_in = q_evt.ok;
            if (q_evt.ok) begin
               for (int i = 0; i < PARTS_MAX; i++) begin
                  if (CNT_W'(i) >= q_evt.count) begin
                     parts_in[i] = '0;
                  end
               end
            end
         end else if (q_evt.ok && first_valid_ff) begin
            res_ord = ord_mid;
            if (ord_mid == ORD_EQ && tail_nz) begin
               res_ord = ORD_GT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PARTS_MAX; i++) begin
            parts_ff[i] <= '0;
         end
         first_valid_ff <= 1'b0;
         run_ord_ff     <= ORD_EQ;
      end else if (q_pop) begin
         parts_ff       <= parts_in;
         first_valid_ff <= first_valid_in;
         run_ord_ff     <= run_ord_in;
      end
   end

   // Hold the result until the beat is taken
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         which_ff <= q_evt.cmd;
         ok_ff    <= q_evt.ok;
         count_ff <= q_evt.count[2:0];
         ord_ff   <= res_ord;
         dg_ff    <= res_ord == ORD_LT;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_which_string = which_ff;
   assign rsp_parse_ok     = ok_ff;
   assign rsp_part_count   = count_ff;
   assign rsp_order        = ord_ff;
   assign rsp_downgrade    = dg_ff;

endmodule

[hw/rtl/version_string_compare.sv]
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_command, req_char_code
// rsp_      out        rsp_valid / rsp_ready  rsp_which_string, rsp_parse_ok,
//                                             rsp_part_count, rsp_order, rsp_downgrade
//
// One byte per cycle is taken while req_ready is high. A terminating byte's event is
// registered in the event queue and then in the comparator's output register. The
// rate is set by the parser and the comparator, which each handle one beat per cycle;
// a stalled result backs up into the two-entry queue and then drops req_ready. Reset
// is synchronous, active high, and clears the parser, the queue, the stored first
// version and the result valid flag.
module version_string_compare #(
   parameter int PARTS_MAX = vsc_pkg::PARTS_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_command,
   input  logic [7:0]        req_char_code,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_which_string,
   output logic              rsp_parse_ok,
   output logic [2:0]        rsp_part_count,
   output logic signed [1:0] rsp_order,
   output logic              rsp_downgrade
);
   import vsc_pkg::*;

   event_type push_evt;
   event_type head_evt;
   logic      q_push, q_pop, q_full, q_empty;

   vsc_front #(.PARTS_MAX(PARTS_MAX)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_char_code (req_char_code),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_evt         (push_evt)
   );

   vsc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_evt (push_evt),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_evt (head_evt)
   );

   vsc_back #(.PARTS_MAX(PARTS_MAX)) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_evt            (head_evt),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_which_string (rsp_which_string),
      .rsp_parse_ok     (rsp_parse_ok),
      .rsp_part_count   (rsp_part_count),
      .rsp_order        (rsp_order),
      .rsp_downgrade    (rsp_downgrade)
   );

   // A first-string result never carries an ordering
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_which_string |-> rsp_order == ORD_EQ && !rsp_downgrade)
      else $error("first-string result carries an ordering");

   // Downgrade flag follows a less-than ordering exactly
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_downgrade == (rsp_order == ORD_LT))
      else $error("downgrade does not match order");

   // An invalid string reports no parts and no ordering
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_parse_ok |-> rsp_part_count == 3'd0 && rsp_order == ORD_EQ)
      else $error("invalid string reports parts or ordering");

   // No result may be raised while the queue has been empty
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!q_empty))
      else $error("result raised without a queued event");

endmodule

[bench/version_string_compare_tb.sv]
module version_string_compare_tb;
   import vsc_pkg::*;

   localparam int PARTS        = PARTS_MAX_DEF;
   localparam int RANDOM_BEATS = 1900;
   localparam int DRAIN_CYCLES = 20000;

   typedef struct {
      logic       cmd;
      logic [7:0] ch;
      bit         drain;
      int         idle_pct;
      int         stall_pct;
   } byte_beat_type;

   typedef struct {
      logic       which;
      logic       ok;
      logic [2:0] count;
      order_type  ord;
      logic       downgrade;
   } verdict_type;

   logic              clock;
   logic              reset         = 1'b1;
   logic              req_valid     = 1'b0;
   logic              req_ready;
   logic              req_command   = 1'b0;
   logic [7:0]        req_char_code = CH_NUL;
   logic              rsp_valid;
   logic              rsp_ready     = 1'b0;
   logic              rsp_which_string;
   logic              rsp_parse_ok;
   logic [2:0]        rsp_part_count;
   logic signed [1:0] rsp_order;
   logic              rsp_downgrade;

   byte_beat_type beat_queue[$];
   verdict_type   verdict_queue[$];
   int         mismatch_count = 0;
   int         cur_idle       = 0;
   int         cur_stall      = 0;
   int         stall_pct      = 0;
   int         random_beats   = 0;
   bit         drain_next     = 1'b0;

   // Parser and comparator state mirrored from the block
   phase_type        ph          = PH_LEAD;
   logic [ACC_W-1:0] acc         = '0;
   int               part_idx    = 0;
   logic [ACC_W-1:0] first_parts[PARTS] = '{default: '0};
   bit               first_valid = 1'b0;
   order_type        run_ord     = ORD_EQ;

   version_string_compare dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_char_code   (req_char_code),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_which_string(rsp_which_string),
      .rsp_parse_ok    (rsp_parse_ok),
      .rsp_part_count  (rsp_part_count),
      .rsp_order       (rsp_order),
      .rsp_downgrade   (rsp_downgrade)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- prediction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   // Store or compare one completed part per its closing command; bad if no room
   task automatic close_part(input logic cmd);
      if (part_idx >= PARTS) begin
         ph = PH_BAD;
      end else begin
         if (!cmd) begin
            first_parts[part_idx] = acc;
         end else if (run_ord == ORD_EQ) begin
            if (first_parts[part_idx] > acc) run_ord = ORD_GT;
            else if (first_parts[part_idx] < acc) run_ord = ORD_LT;
         end
         part_idx++;
         acc = '0;
      end
   endtask

   // Queue the verdict for a terminated string and restart the parser
   task automatic end_string(input logic cmd, input bit ok);
      verdict_type v;
      order_type   ord;
      ord = ORD_EQ;
      if (!cmd) begin
         first_valid = ok;
         if (ok)
            for (int i = part_idx; i < PARTS; i++) first_parts[i] = '0;
      end else if (ok && first_valid) begin
         ord = run_ord;
         if (ord == ORD_EQ)
            for (int i = part_idx; i < PARTS; i++)
               if (first_parts[i] != '0 && ord == ORD_EQ) ord = ORD_GT;
      end
      v.which     = cmd;
      v.ok        = ok;
      v.count     = ok ? 3'(part_idx) : 3'd0;
      v.ord       = ord;
      v.downgrade = (ord == ORD_LT);
      verdict_queue.push_back(v);
      ph       = PH_LEAD;
      acc      = '0;
      part_idx = 0;
      run_ord  = ORD_EQ;
   endtask

   task automatic parse_byte(input logic cmd, input logic [7:0] c);
      case (ph)
         PH_LEAD: begin
            if (c == CH_NUL) end_string(cmd, 1'b0);
            else if (c == CH_SPACE || c == CH_TAB) ;
            else if (c == CH_V_LO || c == CH_V_UP) ph = PH_AFTER_V;
            else if (is_digit(c)) begin
               acc = ACC_W'(c - CH_ZERO);
               ph  = PH_DIGITS;
            end else ph = PH_BAD;
         end
         PH_AFTER_V, PH_AFTER_DOT: begin
            if (c == CH_NUL) end_string(cmd, 1'b0);
            else if (is_digit(c)) begin
               acc = ACC_W'(c - CH_ZERO);
               ph  = PH_DIGITS;
            end else ph = PH_BAD;
         end
         PH_DIGITS: begin
            if (is_digit(c)) begin
               if (acc > PART_LIMIT) ph = PH_BAD;
               else acc = ACC_W'(acc * 10 + (c - CH_ZERO));
            end else if (c == CH_DOT) begin
               close_part(cmd);
               if (ph != PH_BAD) ph = (part_idx >= PARTS) ? PH_BAD : PH_AFTER_DOT;
            end else if (c == CH_NUL) begin
               close_part(cmd);
               end_string(cmd, ph != PH_BAD);
            end else if (c == CH_MINUS || c == CH_PLUS || c == CH_SPACE) begin
               close_part(cmd);
               if (ph != PH_BAD) ph = PH_TAIL;
            end else ph = PH_BAD;
         end
         PH_TAIL: begin
            if (c == CH_NUL) end_string(cmd, 1'b1);
         end
         default: begin
            ph = PH_BAD;
            if (c == CH_NUL) end_string(cmd, 1'b0);
         end
      endcase
   endtask

   // ---------------------------------------------------------------- stimulus

   task automatic push_beat(input logic cmd, input logic [7:0] ch);
      beat_queue.push_back('{cmd: cmd, ch: ch, drain: drain_next,
                             idle_pct: cur_idle, stall_pct: cur_stall});
      drain_next = 1'b0;
      random_beats++;
   endtask

   task automatic push_text(input logic cmd, input string s);
      for (int i = 0; i < s.len(); i++) push_beat(cmd, s[i]);
      push_beat(cmd, CH_NUL);
   endtask

   // Same text, but each beat carries a random command
   task automatic push_mixed(input string s);
      for (int i = 0; i < s.len(); i++) push_beat(1'($urandom_range(0, 1)), s[i]);
      push_beat(1'($urandom_range(0, 1)), CH_NUL);
   endtask

   function automatic longint pick_part();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return $urandom_range(0, 9);
      if (r < 78) return $urandom_range(10, 999);
      if (r < 86) return $urandom_range(1000, 99999999);
      if (r < 96) begin
         case ($urandom_range(0, 4))
            0:       return 99999999;
            1:       return 100000000;
            2:       return 100000001;
            3:       return 1000000009;
            default: return $urandom_range(100000002, 999999999);
         endcase
      end
      return longint'(1000000010) + $urandom_range(0, 9000000);
   endfunction

   task automatic make_parts(output longint p[$]);
      int n;
      p = {};
      n = ($urandom_range(0, 99) < 10) ? PARTS + 1 : $urandom_range(1, PARTS);
      repeat (n) p.push_back(pick_part());
   endtask

   // Running version usually close to the offered one, so that all orderings turn up
   task automatic derive_parts(input longint fp[$], output longint sp[$]);
      int idx;
      sp = fp;
      case ($urandom_range(0, 5))
         2: begin
            idx = $urandom_range(0, sp.size() - 1);
            if ($urandom_range(0, 1) && sp[idx] > 0) sp[idx]--;
            else sp[idx]++;
         end
         3: if (sp.size() > 1) void'(sp.pop_back());
         4: sp.push_back($urandom_range(0, 1) ? 0 : pick_part());
         5: make_parts(sp);
         default: ;
      endcase
   endtask

   function automatic string render(input longint p[$]);
      string s;
      int    r;
      case ($urandom_range(0, 7))
         0:       s = " ";
         1:       s = "\t";
         2:       s = " \t ";
         default: s = "";
      endcase
      r = $urandom_range(0, 99);
      if (r < 15) s = {s, "v"};
      else if (r < 25) s = {s, "V"};
      if ($urandom_range(0, 99) < 5) s = {s, "0"};
      foreach (p[i]) begin
         if (i > 0) s = {s, "."};
         s = {s, $sformatf("%0d", p[i])};
      end
      case ($urandom_range(0, 9))
         0:       s = {s, "-rc1"};
         1:       s = {s, "+build.7"};
         2:       s = {s, " junk"};
         3:       s = {s, "-"};
         4:       s = {s, "+"};
         default: ;
      endcase
      return s;
   endfunction

   // Break the string, except where a tail suffix swallows the appended text
   function automatic string mangle(input string s);
      case ($urandom_range(0, 5))
         0:       return {s, "."};
         1:       return {s, "x"};
         2:       return "v";
         3:       return "";
         4:       return {s, "..", s};
         default: return {"#", s};
      endcase
   endfunction

   task automatic push_version(input logic cmd, input longint p[$], input int bad_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) push_mixed(render(p));
      else if (r < 8) begin
         repeat ($urandom_range(1, 6)) push_beat(cmd, 8'($urandom_range(1, 255)));
         push_beat(cmd, CH_NUL);
      end else if (r < 8 + bad_pct) push_text(cmd, mangle(render(p)));
      else push_text(cmd, render(p));
   endtask

   task automatic directed_beats();
      push_text(1'b1, "1.2");
      push_text(1'b0, "");
      push_text(1'b0, " \tv1.2.3.4");
      push_text(1'b1, "V1.2.3.5-rc");
      push_text(1'b1, "1.2.4");
      push_text(1'b1, "1.2.3.4.5");
      push_text(1'b0, "1.5");
      push_text(1'b1, "1");
      drain_next = 1'b1;
      push_text(1'b0, "1000000009+x");
      push_text(1'b1, "1000000010");
      push_text(1'b1, "999999999 z");
      push_text(1'b0, "1.");
      push_text(1'b1, "1");
      push_text(1'b0, "v");
      push_text(1'b0, "1x");
      // one string spread over both commands
      push_beat(1'b0, "3");
      push_beat(1'b1, ".");
      push_beat(1'b1, "7");
      push_beat(1'b0, CH_NUL);
      push_beat(1'b0, 8'hFF);
      push_beat(1'b1, CH_NUL);
   endtask

   task automatic random_beats_fill();
      longint fp[$];
      longint sp[$];
      int     stage;
      int     last_stage;
      last_stage = -1;
      random_beats = 0;
      while (random_beats < RANDOM_BEATS) begin
         stage = random_beats * 4 / RANDOM_BEATS;
         if (stage != last_stage) begin
            last_stage = stage;
            drain_next = 1'b1;
            case (stage)
               0:       begin cur_idle = 0;  cur_stall = 0;  end
               1:       begin cur_idle = 61; cur_stall = 0;  end
               2:       begin cur_idle = 0;  cur_stall = 61; end
               default: begin cur_idle = 20; cur_stall = 20; end
            endcase
         end
         make_parts(fp);
         push_version(1'b0, fp, 12);
         repeat ($urandom_range(1, 3)) begin
            derive_parts(fp, sp);
            push_version(1'b1, sp, 8);
         end
      end
   endtask

   // ---------------------------------------------------------------- driver

   // Predict each accepted beat, then offer the next one unless idling or draining
   always @(posedge clock) begin
      byte_beat_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) parse_byte(req_command, req_char_code);
         if (!req_valid || req_ready) begin
            if (beat_queue.size() > 0 &&
                (!beat_queue[0].drain || verdict_queue.size() == 0) &&
                $urandom_range(0, 99) >= beat_queue[0].idle_pct) begin
               nxt = beat_queue.pop_front();
               req_valid     <= 1'b1;
               req_command   <= nxt.cmd;
               req_char_code <= nxt.ch;
               stall_pct     <= nxt.stall_pct;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   // Stall at random and check each accepted result beat
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         if (rsp_valid && rsp_ready) begin
            if (verdict_queue.size() == 0) begin
               $display("%0t: expected no result, ", $time,
                        "got which=%0d ok=%0d count=%0d order=%0d dg=%0d",
                        rsp_which_string, rsp_parse_ok, rsp_part_count,
                        rsp_order, rsp_downgrade);
               mismatch_count++;
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_which_string !== want.which || rsp_parse_ok !== want.ok ||
                   rsp_part_count !== want.count || rsp_order !== want.ord ||
                   rsp_downgrade !== want.downgrade) begin
                  $display("%0t: expected which=%0d ok=%0d count=%0d order=%0d dg=%0d, ",
                           $time, want.which, want.ok, want.count, want.ord,
                           want.downgrade,
                           "got which=%0d ok=%0d count=%0d order=%0d dg=%0d",
                           rsp_which_string, rsp_parse_ok,
                           rsp_part_count, rsp_order, rsp_downgrade);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int waited;
      directed_beats();
      random_beats_fill();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // hold until every beat is taken, then let the results drain
      while (beat_queue.size() > 0 || req_valid) @(posedge clock);
      waited = 0;
      while (verdict_queue.size() > 0 && waited < DRAIN_CYCLES) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (verdict_queue.size() > 0) begin
         $display("%0t: %0d expected results never arrived", $time, verdict_queue.size());
         mismatch_count += verdict_queue.size();
      end
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/vsc_pkg.sv
hw/rtl/vsc_front.sv
hw/rtl/vsc_queue.sv
hw/rtl/vsc_back.sv
hw/rtl/version_string_compare.sv
bench/version_string_compare_tb.sv
